@@ hdl/lcls_pkg.sv @@
// Shared types and constants for the line course lap sequencer.
package lcls_pkg;

  localparam int unsigned LAPS = 4;
  localparam int unsigned LapW = 5;

  localparam logic [8:0] DwellMax = 9'd511;

  localparam logic [2:0] RegBlackTicks     = 3'd0;
  localparam logic [2:0] RegWhiteTicks     = 3'd1;
  localparam logic [2:0] RegLevelTolerance = 3'd2;
  localparam logic [2:0] RegFirstSpeed     = 3'd3;
  localparam logic [2:0] RegSecondSpeed    = 3'd4;
  localparam logic [2:0] RegTurnDegrees    = 3'd5;

  typedef enum logic [2:0] {
    PH_DRIVE1 = 3'd0,
    PH_WAIT1  = 3'd1,
    PH_STOP1  = 3'd2,
    PH_DRIVE2 = 3'd3,
    PH_WAIT2  = 3'd4,
    PH_STOP2  = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0]  black_ticks;
    logic [7:0]  white_ticks;
    logic [14:0] level_tolerance;
    logic [14:0] first_speed;
    logic [14:0] second_speed;
  } cfg_t;

  typedef struct packed {
    logic        left_outer;
    logic        left_inner;
    logic        right_inner;
    logic        right_outer;
    logic [15:0] heading;
  } tick_t;

  typedef struct packed {
    logic [14:0] target_speed;
    logic        turn_pulse;
    logic        clear_steer;
    logic        beep_pulse;
    logic [2:0]  phase;
    logic [1:0]  lap;
  } res_t;

endpackage

@@ hdl/lcls_core.sv @@
// Phase sequencer state and per-tick next-state logic.
module lcls_core import lcls_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  step_i,
  input  tick_t tick_i,
  input  cfg_t  cfg_i,
  output res_t  res_o
);

  phase_e      phase_q, phase_d;
  logic [8:0]  dwell_q, dwell_d;
  logic [1:0]  lap_q, lap_d;
  logic        pend_q, pend_d;
  logic [14:0] speed_q, speed_d;

  logic        dark, level, hit, fire, turn, beep, second, waiting;
  logic [7:0]  limit;
  logic [15:0] mag_lo;
  logic [16:0] mag;
  logic [8:0]  dwell_inc, dwell_new;
  logic [LapW-1:0] lap_inc;

  assign dark   = tick_i.left_outer | tick_i.left_inner | tick_i.right_inner
                | tick_i.right_outer;
  assign mag_lo = tick_i.heading[15] ? (~tick_i.heading + 16'd1) : tick_i.heading;
  assign mag    = {(tick_i.heading == 16'h8000), mag_lo};
  assign level  = mag < {2'b00, cfg_i.level_tolerance};
  assign second = (phase_q == PH_DRIVE2);

  assign waiting = (phase_q == PH_WAIT1) || (phase_q == PH_WAIT2);
  assign hit     = waiting ? !dark : dark;
  assign limit   = waiting ? cfg_i.white_ticks : cfg_i.black_ticks;

  assign dwell_inc = (dwell_q == DwellMax) ? DwellMax : dwell_q + 9'd1;
  assign fire      = hit && (dwell_inc > {1'b0, limit});
  assign dwell_new = (!hit || fire) ? 9'd0 : dwell_inc;
  assign lap_inc   = LapW'(lap_q) + LapW'(1);

  always_comb begin
    phase_d = phase_q;
    dwell_d = dwell_q;
    lap_d   = lap_q;
    pend_d  = pend_q;
    speed_d = speed_q;
    turn    = 1'b0;
    beep    = 1'b0;
    case (phase_q)
      PH_WAIT1, PH_WAIT2: begin
        dwell_d = dwell_new;
        if (fire) begin
          beep    = 1'b1;
          phase_d = (phase_q == PH_WAIT1) ? PH_STOP1 : PH_STOP2;
        end
      end
      PH_STOP1: begin
        speed_d = '0;
        if (level) begin
          phase_d = PH_DRIVE2;
          pend_d  = 1'b1;
        end
      end
      PH_STOP2: begin
        speed_d = '0;
        if (level) begin
          lap_d   = ((lap_inc >= LapW'(LAPS)) || (lap_inc > LapW'(3))) ? 2'd0
                                                                       : lap_inc[1:0];
          phase_d = PH_DRIVE1;
          pend_d  = 1'b1;
        end
      end
      default: begin
        phase_d = second ? PH_DRIVE2 : PH_DRIVE1;
        turn    = pend_q;
        pend_d  = 1'b0;
        speed_d = second ? cfg_i.second_speed : cfg_i.first_speed;
        dwell_d = dwell_new;
        if (fire) begin
          beep    = 1'b1;
          phase_d = second ? PH_WAIT2 : PH_WAIT1;
        end
      end
    endcase
  end

  assign res_o = '{target_speed: speed_d, turn_pulse: turn, clear_steer: turn,
                   beep_pulse: beep, phase: phase_d, lap: lap_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DRIVE1;
      dwell_q <= '0;
      lap_q   <= '0;
      pend_q  <= 1'b1;
      speed_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      dwell_q <= dwell_d;
      lap_q   <= lap_d;
      pend_q  <= pend_d;
      speed_q <= speed_d;
    end
  end

  a_no_turn_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && (phase_q == PH_STOP1 || phase_q == PH_STOP2 || phase_q == PH_WAIT1
               || phase_q == PH_WAIT2) |-> !res_o.turn_pulse)
    else $error("turn pulse outside a drive phase");

  a_beep_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.beep_pulse |=> (phase_q == PH_WAIT1 || phase_q == PH_STOP1
                                    || phase_q == PH_WAIT2 || phase_q == PH_STOP2))
    else $error("beep without a debounced phase advance");

  a_turn_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.turn_pulse |=> !pend_q)
    else $error("turn request left pending after pulse");

  a_dwell_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dwell_q <= 9'd255)
    else $error("dwell count beyond any threshold");

endmodule

@@ hdl/line_course_lap_sequencer_top.sv @@
// Line course lap sequencer top level: stream ports, register file, pipeline.
//
// One input beat per sensor tick on the s_axis channel, one result beat per
// tick on the m_axis channel, in order. A tick is captured in an input
// register, evaluated combinationally against the phase state, and written to
// an output register together with the state update.
// A result beat passes through the input and output registers. Throughput:
// one beat per cycle while m_axis_tready is high. When the receiver stalls,
// the result holds in the output register, one more tick waits in the input
// register, and s_axis_tready then drops.
// Reset clears the valid flags of both pipeline registers, sets phase 0, lap 0,
// speed 0 with a turn request pending, and loads the register defaults.
// Registers (APB, byte address 4*i): 0 black_ticks, 1 white_ticks,
// 2 level_tolerance, 3 first_speed, 4 second_speed, 5 turn_degrees.
// Write registers only while no beat is in flight.
module line_course_lap_sequencer_top import lcls_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // left_outer, left_inner, right_inner, right_outer, heading[15:0], zero pad
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // target_speed[14:0], turn_pulse, clear_steer, beep_pulse, phase[2:0],
  // lap[1:0], zero pad
  output logic [23:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t        cfg_q;
  logic [8:0]  turn_deg_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  logic        in_vld_q, out_vld_q;
  tick_t       in_q;
  logic [23:0] out_q;
  logic        adv;
  res_t        res;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.black_ticks     <= 8'd3;
      cfg_q.white_ticks     <= 8'd50;
      cfg_q.level_tolerance <= 15'd50;
      cfg_q.first_speed     <= 15'd3000;
      cfg_q.second_speed    <= 15'd4000;
      turn_deg_q            <= 9'd90;
    end else if (wr_en) begin
      case (reg_idx)
        RegBlackTicks:     cfg_q.black_ticks     <= pwdata[7:0];
        RegWhiteTicks:     cfg_q.white_ticks     <= pwdata[7:0];
        RegLevelTolerance: cfg_q.level_tolerance <= pwdata[14:0];
        RegFirstSpeed:     cfg_q.first_speed     <= pwdata[14:0];
        RegSecondSpeed:    cfg_q.second_speed    <= pwdata[14:0];
        RegTurnDegrees:    turn_deg_q            <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegBlackTicks:     prdata = {24'd0, cfg_q.black_ticks};
      RegWhiteTicks:     prdata = {24'd0, cfg_q.white_ticks};
      RegLevelTolerance: prdata = {17'd0, cfg_q.level_tolerance};
      RegFirstSpeed:     prdata = {17'd0, cfg_q.first_speed};
      RegSecondSpeed:    prdata = {17'd0, cfg_q.second_speed};
      RegTurnDegrees:    prdata = {23'd0, turn_deg_q};
      default:           prdata = '0;
    endcase
  end

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      out_vld_q <= adv || (out_vld_q && !m_axis_tready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q <= '{left_outer: s_axis_tdata[0], left_inner: s_axis_tdata[1],
                right_inner: s_axis_tdata[2], right_outer: s_axis_tdata[3],
                heading: s_axis_tdata[19:4]};
    end
    if (adv) begin
      out_q <= {1'b0, res.lap, res.phase, res.beep_pulse, res.clear_steer,
                res.turn_pulse, res.target_speed};
    end
  end

  lcls_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .tick_i (in_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

endmodule

@@ tb/line_course_lap_sequencer_top_tb.sv @@
// Testbench for the line course lap sequencer: sensor tick stream against a cycle-free predictor.
`timescale 1ns / 1ps

module line_course_lap_sequencer_top_tb;
  import lcls_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int TailCycles    = 8;
  localparam int MaxPrinted    = 40;

  class course_scoreboard;
    logic [7:0]  black_ticks;
    logic [7:0]  white_ticks;
    logic [14:0] level_tol;
    logic [14:0] first_speed;
    logic [14:0] second_speed;
    logic [8:0]  turn_deg;
    logic [2:0]  phase;
    logic [8:0]  dwell;
    logic [1:0]  lap;
    bit          turn_pending;
    logic [14:0] held_speed;
    res_t        expected_ticks[$];
    int          errors;

    function new();
      black_ticks  = 8'd3;
      white_ticks  = 8'd50;
      level_tol    = 15'd50;
      first_speed  = 15'd3000;
      second_speed = 15'd4000;
      turn_deg     = 9'd90;
      phase        = PH_DRIVE1;
      dwell        = '0;
      lap          = '0;
      turn_pending = 1'b1;
      held_speed   = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
      case (idx)
        RegBlackTicks:     black_ticks  = value[7:0];
        RegWhiteTicks:     white_ticks  = value[7:0];
        RegLevelTolerance: level_tol    = value[14:0];
        RegFirstSpeed:     first_speed  = value[14:0];
        RegSecondSpeed:    second_speed = value[14:0];
        RegTurnDegrees:    turn_deg     = value[8:0];
        default: ;
      endcase
    endfunction

    function bit debounce(bit hit, logic [7:0] limit);
      if (!hit) begin
        dwell = '0;
        return 1'b0;
      end
      if (dwell < DwellMax) dwell = dwell + 9'd1;
      if (dwell > limit) begin
        dwell = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_tick(logic [23:0] data);
      bit   dark;
      bit   level;
      bit   second;
      int   h;
      int   mag;
      int   nxt;
      res_t r;
      dark  = |data[3:0];
      h     = int'($signed(data[19:4]));
      mag   = (h < 0) ? -h : h;
      level = mag < int'(level_tol);
      r     = '0;
      case (phase)
        PH_WAIT1, PH_WAIT2: begin
          if (debounce(!dark, white_ticks)) begin
            r.beep_pulse = 1'b1;
            phase = (phase == PH_WAIT1) ? PH_STOP1 : PH_STOP2;
          end
        end
        PH_STOP1: begin
          held_speed = '0;
          if (level) begin
            phase = PH_DRIVE2;
            turn_pending = 1'b1;
          end
        end
        PH_STOP2: begin
          held_speed = '0;
          if (level) begin
            nxt = int'(lap) + 1;
            if (nxt >= int'(LAPS) || nxt > 3) nxt = 0;
            lap = nxt[1:0];
            phase = PH_DRIVE1;
            turn_pending = 1'b1;
          end
        end
        default: begin
          second = (phase == PH_DRIVE2);
          if (!second) phase = PH_DRIVE1;
          if (turn_pending) begin
            r.turn_pulse = 1'b1;
            turn_pending = 1'b0;
          end
          held_speed = second ? second_speed : first_speed;
          if (debounce(dark, black_ticks)) begin
            r.beep_pulse = 1'b1;
            phase = second ? PH_WAIT2 : PH_WAIT1;
          end
        end
      endcase
      r.target_speed = held_speed;
      r.clear_steer  = r.turn_pulse;
      r.phase        = phase;
      r.lap          = lap;
      expected_ticks.push_back(r);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic [23:0] data);
      res_t want;
      if (expected_ticks.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", data));
        return;
      end
      want = expected_ticks.pop_front();
      if (data[14:0] !== want.target_speed)
        report_mismatch($sformatf("target_speed %0d, want %0d", data[14:0], want.target_speed));
      if (data[15] !== want.turn_pulse)
        report_mismatch($sformatf("turn_pulse %b, want %b", data[15], want.turn_pulse));
      if (data[16] !== want.clear_steer)
        report_mismatch($sformatf("clear_steer %b, want %b", data[16], want.clear_steer));
      if (data[17] !== want.beep_pulse)
        report_mismatch($sformatf("beep_pulse %b, want %b", data[17], want.beep_pulse));
      if (data[20:18] !== want.phase)
        report_mismatch($sformatf("phase %0d, want %0d", data[20:18], want.phase));
      if (data[22:21] !== want.lap)
        report_mismatch($sformatf("lap %0d, want %0d", data[22:21], want.lap));
    endtask

    function int pending();
      return expected_ticks.size();
    endfunction
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // left_outer, left_inner, right_inner, right_outer, heading[15:0], zero pad
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // target_speed[14:0], turn_pulse, clear_steer, beep_pulse, phase[2:0], lap[1:0], zero pad
  logic [23:0] m_axis_tdata;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [4:0]  paddr         = '0;
  logic [31:0] pwdata        = '0;
  logic [31:0] prdata;
  logic        pready;

  course_scoreboard sb;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;
  int idle_cycles = 0;

  line_course_lap_sequencer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1;
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
  end

  task send_tick(logic [3:0] sensors, logic [15:0] hdg);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, hdg, sensors};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_tick(s_axis_tdata);
    burst_left--;
  endtask

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(idx, value);
    @(posedge clk_i);
  endtask

  task write_config(logic [31:0] black, logic [31:0] white, logic [31:0] tol,
                    logic [31:0] first, logic [31:0] second, logic [31:0] turn);
    wait_drained();
    write_reg(RegBlackTicks, black);
    write_reg(RegWhiteTicks, white);
    write_reg(RegLevelTolerance, tol);
    write_reg(RegFirstSpeed, first);
    write_reg(RegSecondSpeed, second);
    write_reg(RegTurnDegrees, turn);
  endtask

  function logic [15:0] pick_heading();
    int tol;
    int r;
    int h;
    tol = int'(sb.level_tol);
    r   = $urandom_range(0, 9);
    if (r < 5 && tol > 0) begin
      h = int'($urandom_range(0, 2 * tol - 2)) - (tol - 1);
    end else if (r < 8) begin
      h = $urandom;
    end else if (r == 8) begin
      case ($urandom_range(0, 3))
        0:       h = -32768;
        1:       h = 32767;
        2:       h = -18000;
        default: h = 18000;
      endcase
    end else begin
      h = $urandom_range(0, 1) ? tol : -tol;
    end
    return h[15:0];
  endfunction

  // Mostly debounced runs sized around the thresholds, the rest short noise.
  task run_course(int n_items);
    int         sent;
    int         kind;
    int         len;
    int         base;
    logic [3:0] sensors;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) base = int'(sb.black_ticks) + 1;
      else if (kind < 8) base = int'(sb.white_ticks) + 1;
      else base = 1;
      if (kind >= 8) len = $urandom_range(1, 4);
      else if ($urandom_range(0, 9) < 7) len = base + $urandom_range(0, 2);
      else len = $urandom_range(1, base);
      repeat (len) begin
        if (kind < 4) sensors = 4'($urandom_range(1, 15));
        else if (kind < 8) sensors = 4'b0000;
        else sensors = 4'($urandom_range(0, 15));
        send_tick(sensors, pick_heading());
        sent++;
      end
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= ($urandom_range(0, 7) != 0);
      default: m_axis_tready <= ($urandom_range(0, 4) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || psel) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("line_course_lap_sequencer_top_tb NOT OK");
      $finish;
    end
  end

  initial begin
    int k;
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // register defaults: each sensor alone, fourth dark beat crosses
    send_tick(4'b0001, 16'd0);
    send_tick(4'b0010, 16'd0);
    send_tick(4'b0100, 16'd0);
    send_tick(4'b1000, 16'd0);
    send_tick(4'b0000, 16'h8000);
    send_tick(4'b0000, 16'h7FFF);

    // zero thresholds: walk one full lap through the level boundary
    write_config(32'd0, 32'd0, 32'd100, 32'd1234, 32'd32767, 32'd360);
    send_tick(4'b0000, 16'd100);
    send_tick(4'b0000, 16'd100);
    send_tick(4'b0000, -16'sd100);
    send_tick(4'b0000, 16'h8000);
    send_tick(4'b1111, 16'd99);
    send_tick(4'b1111, 16'd0);
    send_tick(4'b0000, 16'd0);
    send_tick(4'b0000, -16'sd99);
    send_tick(4'b0101, 16'sd18000);
    send_tick(4'b1010, -16'sd18000);
    send_tick(4'b0000, 16'd0);

    write_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    run_course(100);

    write_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_course(600);

    for (k = 0; k < 6; k++) begin
      write_config($urandom_range(0, 6), $urandom_range(0, 8), $urandom_range(1, 18000),
                   $urandom, $urandom, $urandom_range(0, 360));
      if (k == 0) begin
        run_course(65);
        wait_drained();
        run_course(65);
      end else begin
        run_course(130);
      end
    end

    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("line_course_lap_sequencer_top_tb OK");
    end else begin
      $display("line_course_lap_sequencer_top_tb NOT OK");
    end
    $finish;
  end

endmodule
